/* rtl/gm_dfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gm_dfs_pkg;

  // grid geometry
  localparam int SIDE      = 8;
  localparam int CELLS     = SIDE * SIDE;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int COORD_W   = 3;
  localparam int STACK_MAX = 64;
  localparam int SADDR_W   = $clog2(STACK_MAX);
  localparam int DEPTH_W   = $clog2(STACK_MAX + 1);

  // neighbor order tried from each cell, DIR_DONE once all four are used
  typedef enum logic [2:0] {
    DIR_DOWN  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_UP    = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_DONE  = 3'd4
  } dir_t;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // one path stack entry
  typedef struct packed {
    coord_t row;
    coord_t col;
    dir_t   dir;
  } stk_entry_t;

  // bit position of a cell in the open and visited maps
  function automatic logic [CELL_W-1:0] cell_idx(coord_t r, coord_t c);
    return CELL_W'(int'(r) * SIDE + int'(c));
  endfunction

endpackage

`default_nettype wire

/* rtl/grid_maze_dfs_path_finder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Depth-first maze path finder over an 8x8 grid of open/blocked cells held in
// cfg_wr_data (bit row*8+col, 1 = open). One request item carries a start and
// a goal cell; the block answers with the path cells from start to goal
// (found=1, last on the goal), a single found=1 item on the goal when the
// start is the goal, or a single item with found=0 and cell 0,0. A request
// first checks the start, then tries one direction per search step (a push
// happens in that same step) and backtracks by reading the entry below the
// top back from the stack RAM (S_STEP, then S_LOAD). A found path leaves
// while the output is free: each cell read from the RAM (S_E_RD, then
// S_E_LD), then the top cell and the goal (S_E_TOP, S_E_GOAL; with a full
// stack the top cell is last and no goal item follows). A backtrack clears
// the visited mark, so a cell is tried again along every simple path that
// reaches it: search time follows the number of such paths and grows
// exponentially with an open area that does not lead to the goal.
// in_tready is low for the whole request.
module grid_maze_dfs_path_finder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [gm_dfs_pkg::CELLS-1:0]      cfg_wr_data,
  // request channel
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [15:0]                       in_tdata,  // start_row, start_col, goal_row, goal_col
  // result channel
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [7:0]                        out_tdata, // cell_row, cell_col
  output      logic                              out_tuser, // found
  output      logic                              out_tlast  // last
);
  import gm_dfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_STEP,
    S_LOAD,
    S_E_RD,
    S_E_LD,
    S_E_TOP,
    S_E_GOAL,
    S_SINGLE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CELLS-1:0]        open_cells_r;
  logic [CELLS-1:0]        visited_r, visited_nxt;
  coord_t                  start_row_r, start_row_nxt;
  coord_t                  start_col_r, start_col_nxt;
  coord_t                  goal_row_r, goal_row_nxt;
  coord_t                  goal_col_r, goal_col_nxt;
  coord_t                  top_row_r, top_row_nxt;
  coord_t                  top_col_r, top_col_nxt;
  dir_t                    top_dir_r, top_dir_nxt;
  depth_t                  depth_r, depth_nxt;
  logic [SADDR_W-1:0]      emit_idx_r, emit_idx_nxt;
  logic                    found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  coord_t                  out_row_r, out_row_nxt;
  coord_t                  out_col_r, out_col_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_last_r, out_last_nxt;

  // stack RAM
  stk_entry_t              stack_mem [STACK_MAX];
  stk_entry_t              rd_data_r;
  logic                    mem_we;
  logic [SADDR_W-1:0]      mem_waddr;
  stk_entry_t              mem_wdata;
  logic [SADDR_W-1:0]      mem_raddr;

  // neighbor under test
  logic [COORD_W:0]        nr4, nc4;
  logic                    nb_in_grid, nb_enter, nb_goal;
  logic [CELL_W-1:0]       top_idx, nb_idx, start_idx;
  logic                    out_free;
  depth_t                  depth_dec;
  dir_t                    dir_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign top_idx   = cell_idx(top_row_r, top_col_r);
  assign start_idx = cell_idx(start_row_r, start_col_r);
  assign depth_dec = depth_r - depth_t'(1);
  assign dir_inc   = dir_t'(top_dir_r + 3'd1);

  // neighbor coordinates, one bit wider so that steps off the grid stay apart
  always_comb begin
    nr4 = {1'b0, top_row_r};
    nc4 = {1'b0, top_col_r};
    case (top_dir_r)
      DIR_DOWN:  nr4 = {1'b0, top_row_r} + 4'd1;
      DIR_RIGHT: nc4 = {1'b0, top_col_r} + 4'd1;
      DIR_UP:    nr4 = {1'b0, top_row_r} - 4'd1;
      DIR_LEFT:  nc4 = {1'b0, top_col_r} - 4'd1;
      default: ;
    endcase
  end

  assign nb_idx     = cell_idx(nr4[COORD_W-1:0], nc4[COORD_W-1:0]);
  assign nb_in_grid = (nr4 < 4'(SIDE)) && (nc4 < 4'(SIDE));
  assign nb_enter   = nb_in_grid && open_cells_r[nb_idx] && !visited_r[nb_idx];
  assign nb_goal    = (nr4 == {1'b0, goal_row_r}) && (nc4 == {1'b0, goal_col_r});

  // search and readout sequencer
  always_comb begin
    state_nxt     = state_r;
    visited_nxt   = visited_r;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    goal_row_nxt  = goal_row_r;
    goal_col_nxt  = goal_col_r;
    top_row_nxt   = top_row_r;
    top_col_nxt   = top_col_r;
    top_dir_nxt   = top_dir_r;
    depth_nxt     = depth_r;
    emit_idx_nxt  = emit_idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = depth_dec[SADDR_W-1:0];
    mem_wdata     = '{row: top_row_r, col: top_col_r, dir: dir_inc};
    mem_raddr     = emit_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          start_row_nxt = in_tdata[2:0];
          start_col_nxt = in_tdata[5:3];
          goal_row_nxt  = in_tdata[8:6];
          goal_col_nxt  = in_tdata[11:9];
          state_nxt     = S_START;
        end
      end

      S_START: begin
        if (start_row_r == goal_row_r && start_col_r == goal_col_r) begin
          found_nxt = 1'b1;
          state_nxt = S_SINGLE;
        end else if ({1'b0, start_row_r} >= 4'(SIDE) || {1'b0, start_col_r} >= 4'(SIDE) ||
                     !open_cells_r[start_idx]) begin
          found_nxt = 1'b0;
          state_nxt = S_SINGLE;
        end else begin
          top_row_nxt = start_row_r;
          top_col_nxt = start_col_r;
          top_dir_nxt = DIR_DOWN;
          depth_nxt   = depth_t'(1);
          visited_nxt = '0;
          visited_nxt[start_idx] = 1'b1;
          state_nxt   = S_STEP;
        end
      end

      S_STEP: begin
        if (top_dir_r == DIR_DONE) begin
          // backtrack
          visited_nxt[top_idx] = 1'b0;
          depth_nxt = depth_dec;
          if (depth_r == depth_t'(1)) begin
            found_nxt = 1'b0;
            state_nxt = S_SINGLE;
          end else begin
            mem_raddr = SADDR_W'(depth_r - depth_t'(2));
            state_nxt = S_LOAD;
          end
        end else begin
          top_dir_nxt = dir_inc;
          if (nb_goal) begin
            emit_idx_nxt = '0;
            state_nxt    = S_E_RD;
          end else if (nb_enter && depth_r < depth_t'(STACK_MAX)) begin
            // push: park the current top in the RAM
            mem_we      = 1'b1;
            top_row_nxt = nr4[COORD_W-1:0];
            top_col_nxt = nc4[COORD_W-1:0];
            top_dir_nxt = DIR_DOWN;
            depth_nxt   = depth_r + depth_t'(1);
            visited_nxt[nb_idx] = 1'b1;
          end
        end
      end

      S_LOAD: begin
        top_row_nxt = rd_data_r.row;
        top_col_nxt = rd_data_r.col;
        top_dir_nxt = rd_data_r.dir;
        state_nxt   = S_STEP;
      end

      S_E_RD: begin
        if (depth_t'({1'b0, emit_idx_r}) + depth_t'(1) < depth_r) begin
          mem_raddr = emit_idx_r;
          state_nxt = S_E_LD;
        end else begin
          state_nxt = S_E_TOP;
        end
      end

      S_E_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = rd_data_r.row;
          out_col_nxt   = rd_data_r.col;
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          emit_idx_nxt  = emit_idx_r + SADDR_W'(1);
          state_nxt     = S_E_RD;
        end
      end

      S_E_TOP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = top_row_r;
          out_col_nxt   = top_col_r;
          out_found_nxt = 1'b1;
          // a full stack leaves no room for the goal item
          out_last_nxt  = (depth_r == depth_t'(STACK_MAX));
          state_nxt     = (depth_r == depth_t'(STACK_MAX)) ? S_IDLE : S_E_GOAL;
        end
      end

      S_E_GOAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = goal_row_r;
          out_col_nxt   = goal_col_r;
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SINGLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = found_r ? goal_row_r : '0;
          out_col_nxt   = found_r ? goal_col_r : '0;
          out_found_nxt = found_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      open_cells_r <= '0;
      visited_r    <= '0;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        open_cells_r <= cfg_wr_data;
      end
    end
    start_row_r <= start_row_nxt;
    start_col_r <= start_col_nxt;
    goal_row_r  <= goal_row_nxt;
    goal_col_r  <= goal_col_nxt;
    top_row_r   <= top_row_nxt;
    top_col_r   <= top_col_nxt;
    top_dir_r   <= top_dir_nxt;
    emit_idx_r  <= emit_idx_nxt;
    found_r     <= found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  // stack RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= stack_mem[mem_raddr];
  end

  // checks
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= depth_t'(STACK_MAX))
    else $error("stack depth above its limit");

  a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP || state_r == S_LOAD) |-> depth_r != '0)
    else $error("search running on an empty stack");

  a_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP || state_r == S_LOAD) |-> $countones(visited_r) == int'(depth_r))
    else $error("visited map out of step with the stack");

  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> visited_r[top_idx])
    else $error("top of stack not marked visited");

endmodule

`default_nettype wire

/* sim/tb_grid_maze_dfs_path_finder.sv */
`timescale 1ns / 1ps

module tb_grid_maze_dfs_path_finder;
  import gm_dfs_pkg::*;

  localparam int IDLE_PCT      = 17;
  // search steps allowed per request
  localparam int STEP_BUDGET   = 20000;
  localparam int STALL_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 600;
  localparam int GRID_PHASES   = 12;
  localparam int PER_PHASE     = 35;

  // one path cell as it leaves the block
  typedef struct {
    coord_t row;
    coord_t col;
    logic   found;
    logic   last;
  } path_cell_t;

  // Predicts the DFS path for each accepted request and checks result items
  // against it in order.
  class dfs_path_tracker;
    logic [CELLS-1:0] open_map;
    logic [CELLS-1:0] visit_map;
    path_cell_t       pending_cells[$];
    int               errors;

    function new();
      open_map  = '0;
      visit_map = '0;
      errors    = 0;
    endfunction

    function bit enterable(int r, int c);
      if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) return 1'b0;
      return open_map[r*SIDE+c] && !visit_map[r*SIDE+c];
    endfunction

    function void queue_cell(ref path_cell_t cells[$], input int r, input int c,
                             input logic found, input logic last);
      path_cell_t pc;
      pc.row   = coord_t'(r);
      pc.col   = coord_t'(c);
      pc.found = found;
      pc.last  = last;
      cells.push_back(pc);
    endfunction

    // backtracking search, neighbors tried down, right, up, left; gives the
    // steps taken, or -1 once the step budget runs out
    function int predict(coord_t sr, coord_t sc, coord_t gr, coord_t gc,
                         ref path_cell_t cells[$]);
      logic [CELL_W-1:0] stack_pos[STACK_MAX];
      dir_t              stack_dir[STACK_MAX];
      int                depth;
      int                top;
      int                r;
      int                c;
      int                nr;
      int                nc;
      int                steps;
      dir_t              d;
      cells.delete();
      visit_map = '0;
      depth     = 0;
      steps     = 0;
      // start on the goal wins even when the cell is blocked
      if (sr == gr && sc == gc) begin
        queue_cell(cells, gr, gc, 1'b1, 1'b1);
        return 0;
      end
      if (!enterable(sr, sc)) begin
        queue_cell(cells, 0, 0, 1'b0, 1'b1);
        return 0;
      end
      visit_map[sr*SIDE+sc] = 1'b1;
      stack_pos[0] = CELL_W'(sr*SIDE + sc);
      stack_dir[0] = DIR_DOWN;
      depth = 1;
      while (depth > 0) begin
        if (steps >= STEP_BUDGET) return -1;
        steps++;
        top = depth - 1;
        r   = stack_pos[top] / SIDE;
        c   = stack_pos[top] % SIDE;
        d   = stack_dir[top];
        if (d == DIR_DONE) begin
          // all neighbors tried: backtrack
          visit_map[stack_pos[top]] = 1'b0;
          depth--;
          continue;
        end
        stack_dir[top] = dir_t'(d + 1);
        nr = r;
        nc = c;
        case (d)
          DIR_DOWN:  nr = r + 1;
          DIR_RIGHT: nc = c + 1;
          DIR_UP:    nr = r - 1;
          default:   nc = c - 1;
        endcase
        // goal taken on arrival, open or not
        if (nr == int'(gr) && nc == int'(gc)) begin
          for (int i = 0; i < depth; i++)
            queue_cell(cells, stack_pos[i] / SIDE, stack_pos[i] % SIDE, 1'b1, 1'b0);
          if (depth < STACK_MAX) queue_cell(cells, gr, gc, 1'b1, 1'b1);
          else cells[$].last = 1'b1;
          return steps;
        end
        if (enterable(nr, nc) && depth < STACK_MAX) begin
          visit_map[nr*SIDE+nc] = 1'b1;
          stack_pos[depth] = CELL_W'(nr*SIDE + nc);
          stack_dir[depth] = DIR_DOWN;
          depth++;
        end
      end
      queue_cell(cells, 0, 0, 1'b0, 1'b1);
      return steps;
    endfunction

    // true when the search for this request ends within the step budget
    function bit fits_budget(coord_t sr, coord_t sc, coord_t gr, coord_t gc);
      path_cell_t cells[$];
      return predict(sr, sc, gr, gc, cells) >= 0;
    endfunction

    function void add_request(coord_t sr, coord_t sc, coord_t gr, coord_t gc);
      path_cell_t cells[$];
      if (predict(sr, sc, gr, gc, cells) < 0) begin
        errors++;
        $display("%0t: request %0d,%0d to %0d,%0d beyond the step budget",
                 $time, sr, sc, gr, gc);
        return;
      end
      foreach (cells[i]) pending_cells.push_back(cells[i]);
    endfunction

    function void check_cell(coord_t row, coord_t col, logic found, logic last);
      path_cell_t want;
      if (pending_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: row %0d col %0d found %0b last %0b",
                 $time, row, col, found, last);
        return;
      end
      want = pending_cells.pop_front();
      if (row !== want.row) begin
        errors++;
        $display("%0t: cell_row expected %0d actual %0d", $time, want.row, row);
      end
      if (col !== want.col) begin
        errors++;
        $display("%0t: cell_col expected %0d actual %0d", $time, want.col, col);
      end
      if (found !== want.found) begin
        errors++;
        $display("%0t: found expected %0b actual %0b", $time, want.found, found);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CELLS-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;   // start_row, start_col, goal_row, goal_col
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;       // cell_row, cell_col
  logic             out_tuser;       // found
  logic             out_tlast;       // last

  dfs_path_tracker tracker;
  int              idle_pct = IDLE_PCT;
  int              stall_count = 0;

  grid_maze_dfs_path_finder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_cell(out_tdata[2:0], out_tdata[5:3], out_tuser, out_tlast);
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // one request item, with random idle cycles ahead of it
  task automatic send_request(int sr, int sc, int gr, int gc);
    // a search that would run past the step budget is not sent
    if (!tracker.fits_budget(3'(sr), 3'(sc), 3'(gr), 3'(gc))) return;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, 3'(gc), 3'(gr), 3'(sc), 3'(sr)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.add_request(3'(sr), 3'(sc), 3'(gr), 3'(gc));
  endtask

  // hold the sender until every expected item is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_grid(logic [CELLS-1:0] grid);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= grid;
    @(posedge clk);
    tracker.open_map = grid;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CELLS-1:0] random_grid(int pct);
    logic [CELLS-1:0] grid;
    for (int i = 0; i < CELLS; i++) grid[i] = ($urandom_range(99) < pct);
    return grid;
  endfunction

  // mostly an open cell so the search gets going
  function automatic int pick_open(logic [CELLS-1:0] grid);
    int pos;
    pos = $urandom_range(CELLS-1);
    for (int t = 0; t < 32 && !grid[pos]; t++) pos = $urandom_range(CELLS-1);
    return pos;
  endfunction

  initial begin
    int pos;
    int sr;
    int sc;
    int gr;
    int gc;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty grid after reset: start on goal, start blocked
    send_request(3, 4, 3, 4);
    send_request(0, 0, 7, 7);
    send_request(7, 7, 7, 6);

    // fully open grid: corner to corner with long snaking paths, neighbor goals, start on goal
    load_grid('1);
    send_request(0, 0, 7, 7);
    send_request(7, 7, 0, 0);
    send_request(0, 7, 7, 0);
    send_request(7, 0, 0, 7);
    send_request(0, 0, 0, 1);
    send_request(5, 5, 5, 5);
    send_request(3, 3, 2, 3);

    // only the far corner blocked: goal blocked but reachable, start blocked
    load_grid(~(64'h1 << 63));
    send_request(0, 0, 7, 7);
    send_request(7, 7, 0, 0);

    // column 4 walled off
    load_grid(~64'h1010_1010_1010_1010);
    send_request(0, 0, 0, 7);
    send_request(0, 0, 7, 3);
    send_request(0, 5, 4, 4);
    send_request(0, 0, 3, 4);

    // checkerboard: no open neighbors anywhere
    load_grid(64'hAA55_AA55_AA55_AA55);
    send_request(0, 0, 0, 2);
    send_request(0, 0, 1, 0);

    // random grids, mostly searches from open cells
    for (int p = 0; p < GRID_PHASES; p++) begin
      load_grid(random_grid($urandom_range(40, 100)));
      idle_pct = (p == 5 || p == 6) ? 0 : IDLE_PCT;
      for (int k = 0; k < PER_PHASE; k++) begin
        if (p == 2 && k == PER_PHASE / 2) wait_drained();
        // redraw requests whose search would run past the step budget
        do begin
          if ($urandom_range(99) < 85) begin
            pos = pick_open(tracker.open_map);
            sr  = pos / SIDE;
            sc  = pos % SIDE;
          end else begin
            sr = $urandom_range(SIDE-1);
            sc = $urandom_range(SIDE-1);
          end
          if ($urandom_range(99) < 8) begin
            gr = sr;
            gc = sc;
          end else begin
            gr = $urandom_range(SIDE-1);
            gc = $urandom_range(SIDE-1);
          end
        end while (!tracker.fits_budget(3'(sr), 3'(sc), 3'(gr), 3'(gc)));
        send_request(sr, sc, gr, gc);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_cells.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* grid_maze_dfs_path_finder.f */
rtl/gm_dfs_pkg.sv
rtl/grid_maze_dfs_path_finder.sv
sim/tb_grid_maze_dfs_path_finder.sv
